// ----- rtl/aligned_first_fit_extent_allocator_core_assert.svh -----
// assertion macros for the extent allocator core
// relies on i_clk and i_rst_n in the including module
`ifndef ALIGNED_FIRST_FIT_EXTENT_ALLOCATOR_CORE_ASSERT_SVH
`define ALIGNED_FIRST_FIT_EXTENT_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication
`define AFF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AFF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/aff_pkg.sv -----
// types, constants and helpers for the extent allocator
// no dependencies
package aff_pkg;

    localparam int MAX_SLOTS   = 128;
    localparam int ALIGN_LOG2  = 11;
    localparam int SEC_W       = 48;
    localparam int IDX_W       = $clog2(MAX_SLOTS);
    localparam int CNT_W       = $clog2(MAX_SLOTS + 1);
    localparam int SLOT_OUT_W  = 7;
    localparam int ENT_W       = 2 * SEC_W;
    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 64;

    localparam logic [SEC_W-1:0] ALIGN_MASK = SEC_W'((64'd1 << ALIGN_LOG2) - 64'd1);
    localparam logic [SEC_W-1:0] SEC_MAX    = '1;

    localparam logic [SEC_W-1:0] FIRST_RST = SEC_W'(34);
    localparam logic [SEC_W-1:0] LAST_RST  = '0;
    localparam logic [7:0]       SLOTS_RST = 8'(MAX_SLOTS);

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_ALLOC = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_ZERO    = 3'd1,
        ST_NOSPACE = 3'd2,
        ST_BEYOND  = 3'd3,
        ST_NOFREE  = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        REG_FIRST = 2'd0,
        REG_LAST  = 2'd1,
        REG_SLOTS = 2'd2
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FIT,
        S_STEP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [SEC_W-1:0] slot_start;
        logic [SEC_W-1:0] slot_end;
        logic [SEC_W-1:0] request_sectors;
    } t_item;

    typedef struct packed {
        logic [2:0]            status;
        logic [SEC_W-1:0]      granted_start;
        logic [SEC_W-1:0]      granted_end;
        logic [SLOT_OUT_W-1:0] granted_slot;
    } t_result;

    typedef struct packed {
        logic [SEC_W-1:0] lo_sector;
        logic [SEC_W-1:0] hi_sector;
        logic [7:0]       slots_in_use;
    } t_cfg;

    // round up to alignment, carry bit set when leaving the sector range
    function automatic logic [SEC_W:0] round_up(input logic [SEC_W-1:0] v);
        logic [SEC_W:0] r;
        if ((v & ALIGN_MASK) == '0) begin
            r = {1'b0, v};
        end else begin
            r = {1'b0, v | ALIGN_MASK} + (SEC_W+1)'(1);
        end
        return r;
    endfunction

endpackage

// ----- rtl/aff_ram.sv -----
// generic single-write single-read ram with registered read
// no dependencies
module aff_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;
endmodule

// ----- rtl/aff_cfg.sv -----
// apb register block for the extent allocator
// depends on aff_pkg
module aff_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [aff_pkg::ADDR_W-1:0] paddr,
    input  logic [aff_pkg::DATA_W-1:0] pwdata,
    output logic [aff_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output aff_pkg::t_cfg              o_cfg
);
    aff_pkg::t_cfg r_cfg;
    logic [1:0]    idx;
    logic          wr;

    assign idx    = paddr[4:3];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lo_sector    <= aff_pkg::FIRST_RST;
            r_cfg.hi_sector    <= aff_pkg::LAST_RST;
            r_cfg.slots_in_use <= aff_pkg::SLOTS_RST;
        end else if (wr) begin
            unique case (idx)
                aff_pkg::REG_FIRST: r_cfg.lo_sector    <= pwdata[aff_pkg::SEC_W-1:0];
                aff_pkg::REG_LAST:  r_cfg.hi_sector    <= pwdata[aff_pkg::SEC_W-1:0];
                aff_pkg::REG_SLOTS: r_cfg.slots_in_use <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            aff_pkg::REG_FIRST: prdata = aff_pkg::DATA_W'(r_cfg.lo_sector);
            aff_pkg::REG_LAST:  prdata = aff_pkg::DATA_W'(r_cfg.hi_sector);
            aff_pkg::REG_SLOTS: prdata = aff_pkg::DATA_W'(r_cfg.slots_in_use);
            default:            prdata = '0;
        endcase
    end
endmodule

// ----- rtl/aligned_first_fit_extent_allocator_core.sv -----
// extent allocator top level: command fsm, extent store ram, slot valid bits
// depends on aff_pkg, aff_ram, aff_cfg and the assertion header
//
// usage: an item is taken when i_start is high and o_busy is low. load and
// clear items finish at the accepting edge and give no result. an allocate
// gives one result on o_result, marked by o_done for one cycle; the receiver
// cannot stall it. a zero-size allocate answers in the cycle after acceptance.
// otherwise the block walks the extent store once per gap it inspects: each
// walk reads all n slots in use from the ram, one read a cycle, and picks
// the next extent by start; then the fit state checks the gap and, when it
// does not fit, the step state moves past that extent. o_busy is low again
// when o_done is raised. reset empties the store at once through per-slot
// valid bits, restores the register defaults and needs no sweep. configuration
// is to be written over apb only while the block is idle; the block itself
// does not enforce this.
`include "aligned_first_fit_extent_allocator_core_assert.svh"
module aligned_first_fit_extent_allocator_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    output logic                       o_busy,
    input  aff_pkg::t_item             i_item,
    output logic                       o_done,
    output aff_pkg::t_result           o_result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [aff_pkg::ADDR_W-1:0] paddr,
    input  logic [aff_pkg::DATA_W-1:0] pwdata,
    output logic [aff_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    localparam int SW = aff_pkg::SEC_W;
    localparam int IW = aff_pkg::IDX_W;
    localparam int CW = aff_pkg::CNT_W;

    aff_pkg::t_cfg   cfg;
    aff_pkg::t_state r_state, n_state;

    logic [CW-1:0] n_slots;
    logic          accept;

    logic [aff_pkg::MAX_SLOTS-1:0] r_vbit;
    logic [CW-1:0]  r_load_ptr;
    logic [CW-1:0]  r_rd_idx;
    logic           r_chk_v;
    logic [IW-1:0]  r_chk_idx;
    logic [SW-1:0]  r_req, r_start, r_end;
    logic           r_have_prev;
    logic [SW-1:0]  r_ps;
    logic [IW-1:0]  r_pslot;
    logic           r_min_v;
    logic [SW-1:0]  r_min_s, r_min_e;
    logic [IW-1:0]  r_min_slot;
    logic           r_first_pass;
    logic           r_free_v;
    logic [IW-1:0]  r_free_slot;
    logic           r_done;
    aff_pkg::t_result r_res;

    logic                   ram_we;
    logic [IW-1:0]          ram_waddr;
    logic [aff_pkg::ENT_W-1:0] ram_wdata, ram_q;

    logic [SW-1:0] q_s, q_e;
    logic          q_used, q_after, q_better, q_empty, issue;
    logic [SW:0]   first_rnd, step_rnd, fit_sum;
    logic [SW-1:0] lim, step_v;
    logic          fits;
    logic          done_set;

    aff_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    aff_ram #(
        .WIDTH (aff_pkg::ENT_W),
        .DEPTH (aff_pkg::MAX_SLOTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_rd_idx[IW-1:0]),
        .o_rdata (ram_q)
    );

    always_comb begin
        if (cfg.slots_in_use == 8'd0) begin
            n_slots = CW'(1);
        end else if (CW'(cfg.slots_in_use) > CW'(aff_pkg::MAX_SLOTS)) begin
            n_slots = CW'(aff_pkg::MAX_SLOTS);
        end else begin
            n_slots = CW'(cfg.slots_in_use);
        end
    end

    assign o_busy   = (r_state != aff_pkg::S_IDLE);
    assign accept   = i_start && !o_busy;
    assign o_done   = r_done;
    assign o_result = r_res;

    // scan evaluation of the entry returned by the ram
    assign q_s      = r_vbit[r_chk_idx] ? ram_q[aff_pkg::ENT_W-1:SW] : '0;
    assign q_e      = r_vbit[r_chk_idx] ? ram_q[SW-1:0] : '0;
    assign q_used   = (q_s != '0) && (q_e != '0) && (q_s <= q_e);
    assign q_after  = !r_have_prev || (q_s > r_ps) || ((q_s == r_ps) && (r_chk_idx > r_pslot));
    assign q_better = !r_min_v || (q_s < r_min_s);
    assign q_empty  = (q_s == '0) && (q_e == '0);
    assign issue    = (r_state == aff_pkg::S_SCAN) && (r_rd_idx < n_slots);

    assign first_rnd = aff_pkg::round_up(cfg.lo_sector);
    assign step_v    = r_min_e + SW'(1);
    assign step_rnd  = aff_pkg::round_up(step_v);
    assign lim       = r_min_v ? (r_min_s - SW'(1)) : cfg.hi_sector;
    assign fit_sum   = {1'b0, r_start} + {1'b0, r_req} - (SW+1)'(1);
    assign fits      = !fit_sum[SW] && (fit_sum[SW-1:0] <= lim);

    assign done_set = (accept && i_item.cmd == aff_pkg::CMD_ALLOC
                          && (i_item.request_sectors == '0 || first_rnd[SW]))
                   || (r_state == aff_pkg::S_FIT && !fits
                          && (!r_min_v || r_min_e == aff_pkg::SEC_MAX))
                   || (r_state == aff_pkg::S_STEP
                          && (step_rnd[SW] || step_rnd[SW-1:0] > cfg.hi_sector))
                   || (r_state == aff_pkg::S_DONE);

    always_comb begin
        n_state   = r_state;
        ram_we    = 1'b0;
        ram_waddr = r_load_ptr[IW-1:0];
        ram_wdata = {i_item.slot_start, i_item.slot_end};
        unique case (r_state)
            aff_pkg::S_IDLE: begin
                if (accept) begin
                    case (i_item.cmd)
                        aff_pkg::CMD_LOAD: ram_we = (r_load_ptr < n_slots);
                        aff_pkg::CMD_ALLOC: begin
                            if (i_item.request_sectors != '0 && !first_rnd[SW]) begin
                                n_state = aff_pkg::S_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            aff_pkg::S_SCAN: begin
                if (r_chk_v && (CW'(r_chk_idx) == n_slots - CW'(1))) begin
                    n_state = aff_pkg::S_FIT;
                end
            end
            aff_pkg::S_FIT: begin
                if (fits) begin
                    n_state = aff_pkg::S_DONE;
                end else if (!r_min_v || r_min_e == aff_pkg::SEC_MAX) begin
                    n_state = aff_pkg::S_IDLE;
                end else begin
                    n_state = aff_pkg::S_STEP;
                end
            end
            aff_pkg::S_STEP: begin
                if (step_rnd[SW] || step_rnd[SW-1:0] > cfg.hi_sector) begin
                    n_state = aff_pkg::S_IDLE;
                end else begin
                    n_state = aff_pkg::S_SCAN;
                end
            end
            aff_pkg::S_DONE: begin
                n_state   = aff_pkg::S_IDLE;
                ram_waddr = r_free_slot;
                ram_wdata = {r_start, r_end};
                ram_we    = (r_end <= cfg.hi_sector) && r_free_v;
            end
            default: n_state = aff_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= aff_pkg::S_IDLE;
            r_vbit     <= '0;
            r_load_ptr <= '0;
            r_chk_v    <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= done_set;
            r_chk_v <= issue;
            if (ram_we) begin
                r_vbit[ram_waddr] <= 1'b1;
            end
            if (accept && i_item.cmd == aff_pkg::CMD_LOAD && r_load_ptr < n_slots) begin
                r_load_ptr <= r_load_ptr + CW'(1);
            end
            if (accept && i_item.cmd == aff_pkg::CMD_CLEAR) begin
                r_vbit     <= '0;
                r_load_ptr <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_idx <= r_rd_idx[IW-1:0];
        if (issue) begin
            r_rd_idx <= r_rd_idx + CW'(1);
        end
        unique case (r_state)
            aff_pkg::S_IDLE: begin
                r_req        <= i_item.request_sectors;
                r_start      <= first_rnd[SW-1:0];
                r_have_prev  <= 1'b0;
                r_min_v      <= 1'b0;
                r_first_pass <= 1'b1;
                r_free_v     <= 1'b0;
                r_rd_idx     <= '0;
                r_res.granted_start <= '0;
                r_res.granted_end   <= '0;
                r_res.granted_slot  <= '0;
                if (i_item.request_sectors == '0) begin
                    r_res.status <= aff_pkg::ST_ZERO;
                end else begin
                    r_res.status <= aff_pkg::ST_NOSPACE;
                end
            end
            aff_pkg::S_SCAN: begin
                if (r_chk_v) begin
                    if (q_used && q_after && q_better) begin
                        r_min_v    <= 1'b1;
                        r_min_s    <= q_s;
                        r_min_e    <= q_e;
                        r_min_slot <= r_chk_idx;
                    end
                    if (r_first_pass && q_empty && !r_free_v) begin
                        r_free_v    <= 1'b1;
                        r_free_slot <= r_chk_idx;
                    end
                end
            end
            aff_pkg::S_FIT: begin
                r_end <= fit_sum[SW-1:0];
            end
            aff_pkg::S_STEP: begin
                r_start      <= step_rnd[SW-1:0];
                r_have_prev  <= 1'b1;
                r_ps         <= r_min_s;
                r_pslot      <= r_min_slot;
                r_min_v      <= 1'b0;
                r_first_pass <= 1'b0;
                r_rd_idx     <= '0;
            end
            aff_pkg::S_DONE: begin
                if (r_end > cfg.hi_sector) begin
                    r_res.status <= aff_pkg::ST_BEYOND;
                end else if (!r_free_v) begin
                    r_res.status <= aff_pkg::ST_NOFREE;
                end else begin
                    r_res.status        <= aff_pkg::ST_OK;
                    r_res.granted_start <= r_start;
                    r_res.granted_end   <= r_end;
                    r_res.granted_slot  <= aff_pkg::SLOT_OUT_W'(r_free_slot);
                end
            end
            default: ;
        endcase
    end

    `AFF_ASSERT_NOW(a_fit_after_scan, r_state == aff_pkg::S_FIT,
        $past(r_state) == aff_pkg::S_SCAN, "fit check without a finished walk")
    `AFF_ASSERT_NEXT(a_clear_ptr, accept && i_item.cmd == aff_pkg::CMD_CLEAR,
        r_load_ptr == '0 && r_vbit == '0, "clear left slots behind")
    `AFF_ASSERT_NOW(a_ok_order, r_done && r_res.status == aff_pkg::ST_OK,
        r_res.granted_end >= r_res.granted_start, "granted extent reversed")
    `AFF_ASSERT_NEXT(a_write_valid, ram_we, r_vbit[$past(ram_waddr)],
        "written slot not marked valid")
endmodule
